### rtl/core/hfls_pkg.sv
// hfls_pkg: shared types and constants of the hex float literal scanner
// character codes, character class beat, scan phases and result record
// no dependencies
package hfls_pkg;

   localparam int MANT_BITS_DEFAULT = 64;
   localparam int EXP_LIMIT         = 16383;
   localparam int EXP_W             = 15;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A_LO  = 8'h61;
   localparam logic [7:0] CH_F_LO  = 8'h66;
   localparam logic [7:0] CH_A_UP  = 8'h41;
   localparam logic [7:0] CH_F_UP  = 8'h46;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_P_LO  = 8'h70;
   localparam logic [7:0] CH_P_UP  = 8'h50;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;

   typedef enum logic [2:0] {
      PH_INT,
      PH_FRAC,
      PH_ESIGN,
      PH_EDIG,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic       first;
      logic       is_hex;
      logic       is_dec;
      logic       is_dot;
      logic       is_p;
      logic       is_minus;
      logic       is_plus;
      logic [3:0] digit;
   } class_type;

   typedef struct packed {
      logic [63:0]        mantissa;
      logic signed [15:0] binary_exponent;
      logic [15:0]        consumed_count;
      logic               inexact;
      logic               exponent_saturated;
   } result_type;

endpackage

### rtl/core/hfls_front.sv
// hfls_front: classifies one character beat into a class record
// depends on hfls_pkg
module hfls_front (
   input  logic [7:0]          char_code,
   input  logic                first_char,
   output hfls_pkg::class_type cls
);

   logic dec_hit;
   logic lo_hit;
   logic up_hit;

   always_comb begin
      dec_hit = (char_code >= hfls_pkg::CH_ZERO) && (char_code <= hfls_pkg::CH_NINE);
      lo_hit  = (char_code >= hfls_pkg::CH_A_LO) && (char_code <= hfls_pkg::CH_F_LO);
      up_hit  = (char_code >= hfls_pkg::CH_A_UP) && (char_code <= hfls_pkg::CH_F_UP);

      cls.first    = first_char;
      cls.is_dec   = dec_hit;
      cls.is_hex   = dec_hit | lo_hit | up_hit;
      cls.is_dot   = (char_code == hfls_pkg::CH_DOT);
      cls.is_p     = (char_code == hfls_pkg::CH_P_LO) || (char_code == hfls_pkg::CH_P_UP);
      cls.is_minus = (char_code == hfls_pkg::CH_MINUS);
      cls.is_plus  = (char_code == hfls_pkg::CH_PLUS);

      priority if (lo_hit) begin
         cls.digit = 4'(char_code - hfls_pkg::CH_A_LO + 8'd10);
      end else if (up_hit) begin
         cls.digit = 4'(char_code - hfls_pkg::CH_A_UP + 8'd10);
      end else begin
         cls.digit = 4'(char_code - hfls_pkg::CH_ZERO);
      end
   end

endmodule

### rtl/core/hfls_queue.sv
// hfls_queue: short queue of classified beats between front and back
// depends on hfls_pkg
module hfls_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  hfls_pkg::class_type push_data,
   output logic                pop_valid,
   input  logic                pop,
   output hfls_pkg::class_type pop_data
);

   localparam int PTR_W = (hfls_pkg::QUEUE_DEPTH > 1) ? $clog2(hfls_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(hfls_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(hfls_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(hfls_pkg::QUEUE_DEPTH);

   hfls_pkg::class_type entry_ff [hfls_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   always_comb begin
      push_ready = (count_ff != FULL);
      pop_valid  = (count_ff != '0);
      pop_data   = entry_ff[rptr_ff];
      push       = push_valid && push_ready;

      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == LAST) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == LAST) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/hfls_back.sv
// hfls_back: scan state machine and result register
// takes classified beats from the queue, depends on hfls_pkg
module hfls_back #(
   parameter int MANT_BITS = hfls_pkg::MANT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  hfls_pkg::class_type  q_data,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hfls_pkg::result_type rsp_result
);

   localparam int EW = hfls_pkg::EXP_W;

   hfls_pkg::phase_type phase_ff, phase_in, ph;
   logic [MANT_BITS-1:0] mant_ff, mant_in, mant;
   logic [4:0]           frac_ff, frac_in, frac;
   logic [15:0]          drop_ff, drop_in, drop;
   logic [EW-1:0]        eacc_ff, eacc_in, eacc;
   logic                 eneg_ff, eneg_in, eneg;
   logic [15:0]          cnt_ff, cnt_in, cnt;
   logic                 inex_ff, inex_in, inex;
   logic                 sat_ff, sat_in, sat;

   logic                 rsp_valid_ff, rsp_valid_in;
   hfls_pkg::result_type result_ff, result_in;

   logic                 emit;
   logic                 do_hex;
   logic                 do_dec;
   logic                 in_frac;
   logic                 counted;
   logic                 full;
   logic [EW+3:0]        dec_v;
   logic signed [19:0]   e_base;
   logic signed [19:0]   e_sum;
   logic                 clamp;

   always_comb begin
      ph   = q_data.first ? hfls_pkg::PH_INT : phase_ff;
      mant = q_data.first ? '0 : mant_ff;
      frac = q_data.first ? '0 : frac_ff;
      drop = q_data.first ? '0 : drop_ff;
      eacc = q_data.first ? '0 : eacc_ff;
      eneg = q_data.first ? 1'b0 : eneg_ff;
      cnt  = q_data.first ? '0 : cnt_ff;
      inex = q_data.first ? 1'b0 : inex_ff;
      sat  = q_data.first ? 1'b0 : sat_ff;

      phase_in = ph;
      mant_in  = mant;
      frac_in  = frac;
      drop_in  = drop;
      eacc_in  = eacc;
      eneg_in  = eneg;
      inex_in  = inex;
      sat_in   = sat;
      emit     = 1'b0;
      do_hex   = 1'b0;
      do_dec   = 1'b0;
      in_frac  = 1'b0;
      counted  = 1'b0;

      unique case (ph)
         hfls_pkg::PH_INT: begin
            if (q_data.is_hex) begin
               do_hex  = 1'b1;
               counted = 1'b1;
            end else if (q_data.is_dot) begin
               phase_in = hfls_pkg::PH_FRAC;
               counted  = 1'b1;
            end else if (q_data.is_p) begin
               phase_in = hfls_pkg::PH_ESIGN;
               counted  = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         hfls_pkg::PH_FRAC: begin
            if (q_data.is_hex) begin
               do_hex  = 1'b1;
               in_frac = 1'b1;
               counted = 1'b1;
            end else if (q_data.is_p) begin
               phase_in = hfls_pkg::PH_ESIGN;
               counted  = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         hfls_pkg::PH_ESIGN: begin
            if (q_data.is_minus || q_data.is_plus) begin
               eneg_in  = q_data.is_minus;
               phase_in = hfls_pkg::PH_EDIG;
               counted  = 1'b1;
            end else if (q_data.is_dec) begin
               do_dec   = 1'b1;
               phase_in = hfls_pkg::PH_EDIG;
               counted  = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         hfls_pkg::PH_EDIG: begin
            if (q_data.is_dec) begin
               do_dec  = 1'b1;
               counted = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         default: begin
         end
      endcase

      full = |mant[MANT_BITS-1 -: 4];
      if (do_hex) begin
         if (!full) begin
            mant_in = {mant[MANT_BITS-5:0], q_data.digit};
            if (in_frac && (frac != 5'd31)) begin
               frac_in = frac + 5'd1;
            end
         end else begin
            inex_in = 1'b1;
            if (!in_frac && (drop != 16'hffff)) begin
               drop_in = drop + 16'd1;
            end
         end
      end

      dec_v = ((EW+4)'(eacc) << 3) + ((EW+4)'(eacc) << 1) + (EW+4)'(q_data.digit);
      if (do_dec) begin
         if (dec_v > (EW+4)'(hfls_pkg::EXP_LIMIT)) begin
            eacc_in = EW'(hfls_pkg::EXP_LIMIT);
            sat_in  = 1'b1;
         end else begin
            eacc_in = dec_v[EW-1:0];
         end
      end

      cnt_in = cnt;
      if (counted && (cnt != 16'hffff)) begin
         cnt_in = cnt + 16'd1;
      end

      if (emit) begin
         phase_in = hfls_pkg::PH_DONE;
      end

      e_base = eneg ? -$signed({5'b0, eacc}) : $signed({5'b0, eacc});
      e_sum  = e_base + $signed({2'b0, drop, 2'b0}) - $signed({13'b0, frac, 2'b0});
      clamp  = 1'b0;
      result_in.mantissa           = 64'(mant);
      result_in.consumed_count     = cnt;
      result_in.inexact            = inex;
      priority if (e_sum > 20'sd32767) begin
         result_in.binary_exponent = 16'sh7fff;
         clamp = 1'b1;
      end else if (e_sum < -20'sd32768) begin
         result_in.binary_exponent = -16'sh8000;
         clamp = 1'b1;
      end else begin
         result_in.binary_exponent = e_sum[15:0];
      end
      result_in.exponent_saturated = sat | clamp;

      q_pop = q_valid && (!emit || !rsp_valid_ff || rsp_ready);

      if (q_pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= hfls_pkg::PH_INT;
         mant_ff      <= '0;
         frac_ff      <= '0;
         drop_ff      <= '0;
         eacc_ff      <= '0;
         eneg_ff      <= 1'b0;
         cnt_ff       <= '0;
         inex_ff      <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff <= phase_in;
            mant_ff  <= mant_in;
            frac_ff  <= frac_in;
            drop_ff  <= drop_in;
            eacc_ff  <= eacc_in;
            eneg_ff  <= eneg_in;
            cnt_ff   <= cnt_in;
            inex_ff  <= inex_in;
            sat_ff   <= sat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule

### rtl/core/hex_float_literal_scanner_core.sv
// hex_float_literal_scanner_core: top level of the hex float literal scanner
// front classifier, beat queue and scan back end, depends on hfls_pkg
//
// usage
// - req channel: one character beat per handshake; req_first_char starts a new
//   literal and clears the scan state before that character is scanned
// - rsp channel: one beat per literal, issued on the first character that does
//   not belong to it, with mantissa, binary exponent, consumed count and flags
// - characters after the stop give nothing until a beat with req_first_char
// - throughput: one character per cycle unless rsp stalls on a stop beat, set by
//   the combinational scan state update in the back end (shift-add by constants)
// - a stop beat passes through its queue entry, then the back end update into the
//   result register, before it shows on rsp
// - a stalled rsp holds its beat; the back end keeps taking characters that
//   give no result and the two-entry queue absorbs the rest before req_ready
//   drops
// - reset: queue empty, no rsp beat, scan state as at the start of a literal
module hex_float_literal_scanner_core #(
   parameter int MANT_BITS = hfls_pkg::MANT_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   input  logic               req_first_char,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_mantissa,
   output logic signed [15:0] rsp_binary_exponent,
   output logic [15:0]        rsp_consumed_count,
   output logic               rsp_inexact,
   output logic               rsp_exponent_saturated
);

   hfls_pkg::class_type  front_cls;
   hfls_pkg::class_type  q_data;
   logic                 q_valid;
   logic                 q_pop;
   hfls_pkg::result_type result;

   hfls_front u_front (
      .char_code  (req_char_code),
      .first_char (req_first_char),
      .cls        (front_cls)
   );

   hfls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (front_cls),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   hfls_back #(
      .MANT_BITS (MANT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (result)
   );

   assign rsp_mantissa           = result.mantissa;
   assign rsp_binary_exponent    = result.binary_exponent;
   assign rsp_consumed_count     = result.consumed_count;
   assign rsp_inexact            = result.inexact;
   assign rsp_exponent_saturated = result.exponent_saturated;

endmodule
